// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // queue geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PRIO_W     = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CLEAR  = 2'd3
  } spq_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // one stored entry
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [DATA_WIDTH-1:0]    data;
  } spq_entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic       do_insert;
    logic       do_pop;
    spq_entry_t new_entry;
  } spq_cell_ctl_t;

  // 32-bit port word to stored payload width
  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [31:0] word);
    logic [63:0] wide;
    wide = 64'(word);
    return wide[DATA_WIDTH-1:0];
  endfunction

  // stored payload back to 32-bit port word
  function automatic logic [31:0] from_data(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] wide;
    wide = 64'(d);
    return wide[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic          clk,
  input  wire spq_cell_ctl_t ctl,
  input  wire logic          occupied,
  input  wire logic          prev_gt,
  input  wire spq_entry_t    prev_entry,
  input  wire spq_entry_t    next_entry,
  output logic               gt,
  output spq_entry_t         entry
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // new item ranks strictly ahead of this cell, or the cell is empty
  assign gt = !occupied || (ctl.new_entry.prio > entry_r.prio);

  // insert: take new item at the boundary, shift right behind it; pop: shift left
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_insert) begin
      if (gt && !prev_gt) begin
        entry_nxt = ctl.new_entry;
      end else if (gt && prev_gt) begin
        entry_nxt = prev_entry;
      end
    end else if (ctl.do_pop) begin
      entry_nxt = next_entry;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== sv/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue of DEPTH entries, each a signed priority and a payload,
// kept highest priority first with equal priorities in arrival order. An item
// (opcode insert, pop, peek or clear) is accepted when start is high and busy
// is low; busy is high only during reset, so one item can be accepted every
// cycle. Its result appears in the cycle after acceptance, marked by out_valid
// for exactly one cycle, and must be taken then: the receiver cannot stall. An
// insert is a compare-and-shift done in parallel by the row of storage cells,
// each comparing the new priority against its own; a pop shifts the row left.

module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [31:0] in_priority_req,
  input  wire logic [31:0]        in_payload,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [31:0]             out_head_payload,
  output logic signed [31:0]      out_head_priority,
  output logic [4:0]              out_entry_count
);

  logic             busy_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             valid_r;
  spq_status_t      status_r, status_nxt;
  logic [31:0]      head_payload_r, head_payload_nxt;
  logic [31:0]      head_prio_r, head_prio_nxt;

  spq_cell_ctl_t    ctl;
  logic             accept;
  logic             full, empty;
  spq_entry_t       cell_entry [DEPTH];
  logic             cell_gt    [DEPTH];

  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  // decode the operation
  always_comb begin
    ctl.do_insert           = 1'b0;
    ctl.do_pop              = 1'b0;
    ctl.new_entry.prio      = in_priority_req;
    ctl.new_entry.data      = to_data(in_payload);
    count_nxt               = count_r;
    status_nxt              = ST_OK;
    head_payload_nxt        = '0;
    head_prio_nxt           = '0;
    if (accept) begin
      unique case (spq_op_t'(in_opcode))
        OP_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.do_insert = 1'b1;
            count_nxt     = count_r + CNT_W'(1);
          end
        end
        OP_POP, OP_PEEK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_payload_nxt = from_data(cell_entry[0].data);
            head_prio_nxt    = cell_entry[0].prio;
            if (spq_op_t'(in_opcode) == OP_POP) begin
              ctl.do_pop = 1'b1;
              count_nxt  = count_r - CNT_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // row of storage cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       occ;
    logic       prev_gt;
    spq_entry_t prev_entry;
    spq_entry_t next_entry;

    assign occ = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign prev_gt    = 1'b0;
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_gt    = cell_gt[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_notlast
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ),
      .prev_gt    (prev_gt),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .gt         (cell_gt[i]),
      .entry      (cell_entry[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    status_r       <= status_nxt;
    head_payload_r <= head_payload_nxt;
    head_prio_r    <= head_prio_nxt;
  end

  assign busy              = busy_r;
  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_head_payload  = head_payload_r;
  assign out_head_priority = head_prio_r;
  assign out_entry_count   = 5'(count_r);

`ifndef SYNTH
  // one result for every accepted item, in the following cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> valid_r)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !valid_r)
    else $error("result without an accepted item");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  // a dropped insert leaves the queue full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_FULL) |-> count_r == CNT_W'(DEPTH))
    else $error("full status while queue not full");

  // empty status only with nothing held
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_EMPTY) |-> count_r == '0)
    else $error("empty status while queue holds entries");
`endif

endmodule

`default_nettype wire

// ===== tb/sorted_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 700;
  localparam int CALM_TAIL    = 100;
  localparam logic signed [31:0] PRIO_TOP = 32'sh7fffffff;
  localparam logic signed [31:0] PRIO_BOT = 32'sh80000000;

  // one result as the block should report it
  typedef struct packed {
    spq_status_t        status;
    logic [31:0]        head_payload;
    logic signed [31:0] head_priority;
    logic [4:0]         entry_count;
  } pq_result_t;

  // shadow copy of the queue plus the list of results still due
  class queue_shadow;
    logic signed [31:0] prio_row[DEPTH];
    logic [31:0]        data_row[DEPTH];
    int unsigned        held;
    pq_result_t         due_results[$];
    int                 errors;
    int                 items_seen;
    int                 results_seen;
    int                 op_hits[4];
    int                 full_hits;
    int                 empty_hits;
    int unsigned        peak_held;

    function new();
      held = 0;
      errors = 0;
      items_seen = 0;
      results_seen = 0;
      full_hits = 0;
      empty_hits = 0;
      peak_held = 0;
      foreach (op_hits[i]) op_hits[i] = 0;
      foreach (prio_row[i]) begin
        prio_row[i] = '0;
        data_row[i] = '0;
      end
    endfunction

    // apply one accepted item to the shadow and queue its result
    function void note_item(spq_op_t op, logic signed [31:0] prio, logic [31:0] pay);
      pq_result_t r;
      int unsigned pos;
      bit found;
      r = '{status: ST_OK, head_payload: '0, head_priority: '0, entry_count: '0};
      items_seen++;
      op_hits[op]++;
      case (op)
        OP_INSERT: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
            full_hits++;
          end else begin
            // new entry goes after every entry of greater or equal priority
            pos = held;
            found = 0;
            for (int i = 0; i < held; i++) begin
              if (!found && prio > prio_row[i]) begin
                pos = i;
                found = 1;
              end
            end
            for (int i = held; i > pos; i--) begin
              prio_row[i] = prio_row[i-1];
              data_row[i] = data_row[i-1];
            end
            prio_row[pos] = prio;
            data_row[pos] = pay;
            held++;
            if (held > peak_held) peak_held = held;
          end
        end
        OP_POP, OP_PEEK: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
            empty_hits++;
          end else begin
            r.head_payload  = data_row[0];
            r.head_priority = prio_row[0];
            if (op == OP_POP) begin
              for (int i = 1; i < held; i++) begin
                prio_row[i-1] = prio_row[i];
                data_row[i-1] = data_row[i];
              end
              held--;
            end
          end
        end
        default: held = 0;
      endcase
      r.entry_count = 5'(held);
      due_results.push_back(r);
    endfunction

    // compare one result against the oldest one due
    function void check_result(logic [1:0] st, logic [31:0] pay, logic signed [31:0] prio,
                               logic [4:0] cnt);
      pq_result_t e;
      results_seen++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result %0d: status %0d payload %h priority %h count %0d",
                   results_seen, st, pay, prio, cnt);
        return;
      end
      e = due_results.pop_front();
      if (e.status !== spq_status_t'(st) || e.head_payload !== pay ||
          e.head_priority !== prio || e.entry_count !== cnt) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch on result %0d: status exp %0d got %0d, payload exp %h got %h,",
                    " priority exp %h got %h, count exp %0d got %0d"},
                   results_seen, e.status, st, e.head_payload, pay,
                   e.head_priority, prio, e.entry_count, cnt);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_opcode = OP_PEEK;
  logic signed [31:0] in_priority_req = '0;
  logic [31:0]        in_payload = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [31:0]        out_head_payload;
  logic signed [31:0] out_head_priority;
  logic [4:0]         out_entry_count;

  queue_shadow shadow = new();
  int          quiet_cycles = 0;

  sorted_priority_queue_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_priority_req  (in_priority_req),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_payload (out_head_payload),
    .out_head_priority(out_head_priority),
    .out_entry_count  (out_entry_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch both channels at each edge, and stop a hung run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        shadow.check_result(out_status, out_head_payload, out_head_priority, out_entry_count);
      if (start && !busy)
        shadow.note_item(spq_op_t'(in_opcode), in_priority_req, in_payload);
      if (out_valid || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(spq_op_t op, logic signed [31:0] prio, logic [31:0] pay);
    in_opcode       <= op;
    in_priority_req <= prio;
    in_payload      <= pay;
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // priorities: many near zero for ties, some extremes, some anywhere
  function automatic logic signed [31:0] pick_priority();
    logic signed [31:0] p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = 32'($signed($urandom_range(0, 6))) - 32'sd3;
      4:          p = PRIO_TOP;
      5:          p = PRIO_BOT;
      6:          p = PRIO_TOP - 32'($urandom_range(0, 2));
      7:          p = PRIO_BOT + 32'($urandom_range(0, 2));
      default:    p = $urandom;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] pick_payload();
    logic [31:0] d;
    case ($urandom_range(0, 15))
      0:       d = '0;
      1:       d = '1;
      default: d = $urandom;
    endcase
    return d;
  endfunction

  // fill phases lean to inserts, drain phases to pops
  function automatic spq_op_t pick_op(bit filling);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < (filling ? 62 : 30)) return OP_INSERT;
    if (r < 85 + (filling ? 2 : 0)) return OP_POP;
    if (r < 99) return OP_PEEK;
    return OP_CLEAR;
  endfunction

  initial begin
    bit filling;
    bit gaps_on;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty reads, extreme priorities, ties, full queue, clear
    send_item(OP_PEEK, 32'sd7, 32'h1234_5678);
    send_item(OP_POP, PRIO_TOP, '1);
    send_item(OP_INSERT, PRIO_BOT, '1);
    send_item(OP_INSERT, PRIO_TOP, '0);
    send_item(OP_INSERT, 32'sd0, 32'haaaa_aaaa);
    send_item(OP_INSERT, 32'sd0, 32'h5555_5555);
    send_item(OP_PEEK, '0, '0);
    send_item(OP_POP, '0, '0);
    for (int i = 0; i < 13; i++)
      send_item(OP_INSERT, 32'(i % 3) - 32'sd1, 32'h100 + 32'(i));
    send_item(OP_INSERT, PRIO_TOP, 32'hdead_beef);
    send_item(OP_PEEK, '0, '0);
    send_item(OP_CLEAR, '1, '1);

    // random: alternating fill and drain phases, gaps in random stretches
    filling = 1;
    gaps_on = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) filling = !filling || (n == 0);
      if (n % 50 == 0) gaps_on = ($urandom_range(0, 9) < 7);
      if (gaps_on && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0)
        idle($urandom_range(1, 16));
      send_item(pick_op(filling), pick_priority(), pick_payload());
    end
    start <= 1'b0;

    // drain the remaining results
    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("ran %0d items (%0d insert, %0d pop, %0d peek, %0d clear), checked %0d results",
             shadow.items_seen, shadow.op_hits[OP_INSERT], shadow.op_hits[OP_POP],
             shadow.op_hits[OP_PEEK], shadow.op_hits[OP_CLEAR], shadow.results_seen);
    $display("full rejects %0d, empty reads %0d, deepest fill %0d, errors %0d",
             shadow.full_hits, shadow.empty_hits, shadow.peak_held, shadow.errors);
    if (shadow.errors == 0 && shadow.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_top.sv
tb/sorted_priority_queue_top_tb.sv
